>>> hw/rtl/bfei_pkg.sv
// ----------------------------------------------------------------------------
// bfei_pkg
// Shared types, codes and helper functions of the bit field extract/insert
// engine.
// ----------------------------------------------------------------------------
package bfei_pkg;

    localparam int CMD_W    = 2;
    localparam int OFF_W    = 10;
    localparam int LEN_W    = 7;
    localparam int VAL_W    = 64;
    localparam int IDX_W    = 6;
    localparam int BYTE_W   = 8;
    localparam int STAT_W   = 2;
    localparam int FRAME_W  = 7;
    // a field spans at most nine bytes once its start bit is added
    localparam int WIN_BYTES = 9;
    localparam int WIN_W     = WIN_BYTES * BYTE_W;
    localparam int LANE_W    = 4;
    localparam int SHAMT_W   = 7;

    localparam logic [FRAME_W-1:0] FRAME_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD,
        CMD_READ,
        CMD_EXTRACT,
        CMD_INSERT
    } cmd_t;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_LEN = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BEYOND  = 2'd2;

    // low len bits set, all ones for 64 and up
    function automatic logic [VAL_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [VAL_W-1:0] m;
        if (len >= 7'd64) begin
            m = '1;
        end else begin
            m = (64'd1 << len) - 64'd1;
        end
        return m;
    endfunction

    // reverse the low ceil(len/8) bytes, upper bytes cleared
    function automatic logic [VAL_W-1:0] byte_rev(input logic [VAL_W-1:0] v,
                                                  input logic [LEN_W-1:0] len);
        logic [LANE_W-1:0] cnt;
        logic [LANE_W-1:0] src;
        logic [VAL_W-1:0]  r;
        cnt = LANE_W'((len + 7'd7) >> 3);
        r   = '0;
        for (int j = 0; j < 8; j++) begin
            if (LANE_W'(j) < cnt) begin
                src = cnt - 4'd1 - LANE_W'(j);
                r[8*j +: 8] = v[8*src[2:0] +: 8];
            end
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/bit_field_extract_insert.sv
// field commands pass over the n bytes that the field spans (n = 1..9) before the result is valid
// byte read passes through S_RBYTE, byte load and rejected commands go straight to S_DONE
// a new item is taken only in S_IDLE, once the frame buffer (one read, one write port) is done
// next item is accepted the cycle after the result is registered, even if it waits
// reset (aresetn, synchronous, active low): sequencer idle, no result, frame_bytes = 64
// buffer contents are not cleared by reset
// ----------------------------------------------------------------------------
// bit_field_extract_insert
// Frame byte buffer with byte load/read and bit field extract/insert of 1 to
// 64 bits at any bit offset, LSB-first or MSB-first, with optional byte swap.
// ----------------------------------------------------------------------------
module bit_field_extract_insert #(
    parameter int BUF_BYTES = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write channel (frame_bytes)
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bfei_pkg::FRAME_W-1:0]     cfg_data,
    // input items
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [bfei_pkg::CMD_W-1:0]       s_cmd,
    input  logic [bfei_pkg::OFF_W-1:0]       s_bit_offset,
    input  logic [bfei_pkg::LEN_W-1:0]       s_bit_length,
    input  logic                             s_msb_first,
    input  logic                             s_big_endian,
    input  logic [bfei_pkg::VAL_W-1:0]       s_field_value,
    input  logic [bfei_pkg::IDX_W-1:0]       s_byte_index,
    input  logic [bfei_pkg::BYTE_W-1:0]      s_byte_value,
    // result items
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [bfei_pkg::VAL_W-1:0]       m_read_value,
    output logic [bfei_pkg::STAT_W-1:0]      m_status
);
    import bfei_pkg::*;

    localparam int AW = $clog2(BUF_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RBYTE,
        S_XFORM,
        S_ALIGN,
        S_ACCESS,
        S_DONE
    } state_t;

    // frame buffer, one read and one write port, registered read
    logic [BYTE_W-1:0] mem [BUF_BYTES];
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;

    // sequencer and datapath registers
    state_t              state_reg;
    logic [FRAME_W-1:0]  frame_bytes_reg;
    logic                is_insert_reg;
    logic                msb_reg;
    logic                swap_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [SHAMT_W-1:0]  lo_reg;       // bit position of the field inside the window
    logic [LANE_W-1:0]   nbytes_reg;
    logic [LANE_W-1:0]   cnt_reg;
    logic [AW-1:0]       addr_reg;
    logic [AW-1:0]       wr_addr_reg;
    logic [WIN_W-1:0]    win_reg;      // gathered bytes, or aligned insert data
    logic [WIN_W-1:0]    wmask_reg;    // bits of the window that the insert owns
    logic [VAL_W-1:0]    val_reg;
    logic [VAL_W-1:0]    res_reg;
    logic [STAT_W-1:0]   stat_reg;
    logic                m_valid_reg;
    logic [VAL_W-1:0]    m_read_value_reg;
    logic [STAT_W-1:0]   m_status_reg;

    // accept-side decode
    logic                accept;
    cmd_t                cmd_in;
    logic                byte_bad;
    logic                len_bad;
    logic                bound_bad;
    logic [FRAME_W-1:0]  eff_bytes;
    logic [OFF_W:0]      end_bit;
    logic [2:0]          sh_in;
    logic [SHAMT_W-1:0]  lo_in;
    logic [LEN_W-1:0]    span_in;

    // shared units
    logic [WIN_W-1:0]    shift_out;
    logic [VAL_W-1:0]    lmask;
    logic [VAL_W-1:0]    xform_out;
    logic [WIN_W-1:0]    field_mask;
    logic [LANE_W-1:0]   lane;
    logic [BYTE_W-1:0]   win_lane;
    logic [BYTE_W-1:0]   mask_lane;

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == S_IDLE);
    assign accept       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;

    always_comb begin
        cmd_in    = cmd_t'(s_cmd);
        byte_bad  = (32'(s_byte_index) >= 32'(BUF_BYTES));
        len_bad   = (s_bit_length == '0) || (s_bit_length > 7'd64);
        // only the smaller of frame_bytes and the buffer size counts
        eff_bytes = (32'(frame_bytes_reg) < 32'(BUF_BYTES)) ? frame_bytes_reg
                                                            : FRAME_W'(BUF_BYTES);
        end_bit   = (OFF_W+1)'(s_bit_offset) + (OFF_W+1)'(s_bit_length);
        bound_bad = (end_bit > (OFF_W+1)'({eff_bytes, 3'b000}));
        sh_in     = s_bit_offset[2:0];
        // msb-first keeps the first byte at the top of the window
        lo_in     = s_msb_first ? SHAMT_W'(8'd72 - 8'(sh_in) - 8'(s_bit_length))
                                : SHAMT_W'(sh_in);
        span_in   = (LEN_W'(sh_in) + s_bit_length + 7'd7) >> 3;
    end

    // one barrel shifter: aligns insert data up, gathered bytes down
    assign shift_out = is_insert_reg ? (WIN_W'(val_reg) << lo_reg) : (win_reg >> lo_reg);

    // one mask/swap unit for both directions
    always_comb begin
        lmask     = len_mask(len_reg);
        xform_out = swap_reg ? (byte_rev(val_reg & lmask, len_reg) & lmask)
                             : (val_reg & lmask);
    end

    always_comb begin
        for (int j = 0; j < WIN_W; j++) begin
            field_mask[j] = (SHAMT_W'(j) >= lo_reg) &&
                            (8'(j) < (8'(lo_reg) + 8'(len_reg)));
        end
    end

    // window lane of the byte that arrives this cycle (byte cnt - 1)
    always_comb begin
        lane      = msb_reg ? (4'd9 - cnt_reg) : (cnt_reg - 4'd1);
        win_lane  = '0;
        mask_lane = '0;
        for (int j = 0; j < WIN_BYTES; j++) begin
            if (lane == LANE_W'(j)) begin
                win_lane  = win_reg[8*j +: 8];
                mask_lane = wmask_reg[8*j +: 8];
            end
        end
    end

    // buffer port steering
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = addr_reg;
        wr_en   = 1'b0;
        wr_addr = wr_addr_reg;
        wr_data = (rd_data_reg & ~mask_lane) | (win_lane & mask_lane);
        unique case (state_reg)
            S_IDLE: begin
                rd_addr = AW'(s_byte_index);
                wr_addr = AW'(s_byte_index);
                wr_data = s_byte_value;
                rd_en   = accept && (cmd_in == CMD_READ) && !byte_bad;
                wr_en   = accept && (cmd_in == CMD_LOAD) && !byte_bad;
            end
            S_ACCESS: begin
                rd_en = (cnt_reg < nbytes_reg);
                wr_en = is_insert_reg && (cnt_reg != '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_bytes_reg <= FRAME_RESET;
        end else if (cfg_valid && cfg_ready) begin
            frame_bytes_reg <= cfg_data;
        end
    end

    // sequencer, datapath and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // in S_DONE the result register is handled below
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        is_insert_reg <= (cmd_in == CMD_INSERT);
                        msb_reg       <= s_msb_first;
                        swap_reg      <= (s_bit_length > 7'd8) &&
                                         (s_msb_first ? !s_big_endian : s_big_endian);
                        len_reg       <= s_bit_length;
                        lo_reg        <= lo_in;
                        nbytes_reg    <= LANE_W'(span_in);
                        cnt_reg       <= '0;
                        addr_reg      <= AW'(s_bit_offset >> 3);
                        val_reg       <= s_field_value;
                        res_reg       <= '0;
                        unique case (cmd_in)
                            CMD_LOAD: begin
                                stat_reg  <= byte_bad ? STAT_BEYOND : STAT_OK;
                                state_reg <= S_DONE;
                            end
                            CMD_READ: begin
                                if (byte_bad) begin
                                    stat_reg  <= STAT_BEYOND;
                                    state_reg <= S_DONE;
                                end else begin
                                    stat_reg  <= STAT_OK;
                                    state_reg <= S_RBYTE;
                                end
                            end
                            CMD_EXTRACT, CMD_INSERT: begin
                                // length is checked before bounds
                                priority if (len_bad) begin
                                    stat_reg  <= STAT_BAD_LEN;
                                    state_reg <= S_DONE;
                                end else if (bound_bad) begin
                                    stat_reg  <= STAT_BEYOND;
                                    state_reg <= S_DONE;
                                end else if (cmd_in == CMD_INSERT) begin
                                    stat_reg  <= STAT_OK;
                                    state_reg <= S_XFORM;
                                end else begin
                                    stat_reg  <= STAT_OK;
                                    state_reg <= S_ACCESS;
                                end
                            end
                            default: begin
                                stat_reg  <= STAT_OK;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RBYTE: begin
                    res_reg   <= VAL_W'(rd_data_reg);
                    state_reg <= S_DONE;
                end
                S_XFORM: begin
                    // insert: mask and swap the value before it is placed
                    // extract: mask and swap the gathered field into the result
                    if (is_insert_reg) begin
                        val_reg   <= xform_out;
                        state_reg <= S_ALIGN;
                    end else begin
                        res_reg   <= xform_out;
                        state_reg <= S_DONE;
                    end
                end
                S_ALIGN: begin
                    if (is_insert_reg) begin
                        win_reg   <= shift_out;
                        wmask_reg <= field_mask;
                        state_reg <= S_ACCESS;
                    end else begin
                        val_reg   <= shift_out[VAL_W-1:0];
                        state_reg <= S_XFORM;
                    end
                end
                S_ACCESS: begin
                    // read byte cnt, and handle byte cnt - 1 whose data is back
                    cnt_reg     <= cnt_reg + 4'd1;
                    addr_reg    <= addr_reg + AW'(1);
                    wr_addr_reg <= addr_reg;
                    if (!is_insert_reg && (cnt_reg != '0)) begin
                        for (int j = 0; j < WIN_BYTES; j++) begin
                            if (lane == LANE_W'(j)) begin
                                win_reg[8*j +: 8] <= rd_data_reg;
                            end
                        end
                    end
                    if (cnt_reg == nbytes_reg) begin
                        state_reg <= is_insert_reg ? S_DONE : S_ALIGN;
                    end
                end
                S_DONE: begin
                    // wait for the result register to be free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg      <= 1'b1;
                        m_read_value_reg <= res_reg;
                        m_status_reg     <= stat_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
